>>> rtl/core/b64e_pkg.sv
// Shared types, constants and the character table of the Base64 stream encoder.
`timescale 1ns / 1ps

package b64e_pkg;

	localparam int unsigned GROUP_QUEUE_DEPTH = 2;
	localparam logic [7:0]  PAD_CODE          = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} out_word_t;

	typedef enum logic [1:0] {
		PAD_NONE = 2'd0,
		PAD_ONE  = 2'd1,
		PAD_TWO  = 2'd2
	} pad_t;

	// One complete 24-bit group together with its padding and end mark.
	typedef struct packed {
		logic [23:0] bits;
		pad_t        npad;
		logic        fin;
	} group_t;

	function automatic logic [7:0] b64_char(input logic [5:0] idx);
		logic [7:0] code;
		if (idx < 6'd26) begin
			code = 8'h41 + {2'b00, idx};
		end else if (idx < 6'd52) begin
			code = 8'h61 + {2'b00, idx - 6'd26};
		end else if (idx < 6'd62) begin
			code = 8'h30 + {2'b00, idx - 6'd52};
		end else if (idx == 6'd62) begin
			code = 8'h2B;
		end else begin
			code = 8'h2F;
		end
		return code;
	endfunction

endpackage

>>> rtl/core/b64e_front.sv
// Front end: packs bytes into 24-bit groups, pads a short last one, hands them on.
`timescale 1ns / 1ps

module b64e_front
	import b64e_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t item,
	output logic     grp_push,
	output group_t   grp_data,
	input  logic     grp_full
);

	logic [15:0] pending_q;
	logic [1:0]  count_q;
	logic        accept;

	assign full   = grp_full;
	assign accept = push && !grp_full;

	always_comb begin
		grp_push      = 1'b0;
		grp_data.bits = {pending_q, item.data_byte};
		grp_data.npad = PAD_NONE;
		grp_data.fin  = item.last_byte;
		if (count_q >= 2'd2) begin
			grp_push = accept;
		end else if (item.last_byte) begin
			grp_push      = accept;
			grp_data.fin  = 1'b1;
			if (count_q == 2'd0) begin
				grp_data.bits = {item.data_byte, 16'h0000};
				grp_data.npad = PAD_TWO;
			end else begin
				grp_data.bits = {pending_q[7:0], item.data_byte, 8'h00};
				grp_data.npad = PAD_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (count_q >= 2'd2 || item.last_byte) begin
				pending_q <= '0;
				count_q   <= '0;
			end else begin
				pending_q <= {pending_q[7:0], item.data_byte};
				count_q   <= count_q + 2'd1;
			end
		end
	end

	// A group is only ever handed on together with an accepted byte.
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		grp_push |-> accept)
		else $error("group pushed without an accepted word");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("pending count out of range");

endmodule

>>> rtl/core/b64e_queue.sv
// Short group queue that decouples the front end from the character serialiser.
`timescale 1ns / 1ps

module b64e_queue
	import b64e_pkg::*;
#(
	parameter int unsigned DEPTH = GROUP_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  group_t wr_data,
	output logic   full,
	output logic   rd_valid,
	output group_t rd_data,
	input  logic   rd_en
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	group_t          slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slots_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("group queue overfilled");

endmodule

>>> rtl/core/b64e_back.sv
// Back end: turns each queued group into four characters, one per cycle while the output word is free.
`timescale 1ns / 1ps

module b64e_back
	import b64e_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      grp_valid,
	input  group_t    grp_data,
	output logic      grp_take,
	output logic      empty,
	input  logic      pop,
	output out_word_t result
);

	group_t     cur_q;
	logic       active_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_q;
	logic       out_free;
	logic       load_char;
	logic       finishing;
	logic [5:0] slice;
	logic       is_pad;
	out_word_t  next_char;

	assign out_free  = !out_valid_q || pop;
	assign load_char = active_q && out_free;
	assign finishing = load_char && (idx_q == 2'd3);
	assign grp_take  = grp_valid && (!active_q || finishing);
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_comb begin
		case (idx_q)
			2'd0:    slice = cur_q.bits[23:18];
			2'd1:    slice = cur_q.bits[17:12];
			2'd2:    slice = cur_q.bits[11:6];
			default: slice = cur_q.bits[5:0];
		endcase
		is_pad = ((cur_q.npad == PAD_TWO) && idx_q[1])
			|| ((cur_q.npad != PAD_NONE) && (idx_q == 2'd3));
		next_char.char_code = is_pad ? PAD_CODE : b64_char(slice);
		next_char.last_char = cur_q.fin && (idx_q == 2'd3);
	end

	always_ff @(posedge clk) begin
		if (grp_take) begin
			cur_q <= grp_data;
		end
		if (load_char) begin
			out_q <= next_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (grp_take) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (finishing) begin
				active_q <= 1'b0;
			end else if (load_char) begin
				idx_q <= idx_q + 2'd1;
			end
			if (load_char) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// While the output word is blocked the character position must not move.
	a_stall_holds_idx: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !out_free |=> $stable(idx_q))
		else $error("character index moved during stall");

	a_new_group_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		grp_take |=> active_q && (idx_q == 2'd0))
		else $error("new group did not start at the first character");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finishing && !grp_take |=> !active_q)
		else $error("serialiser stayed busy after the fourth character");

endmodule

>>> rtl/core/base64_stream_encoder.sv
// Base64 stream encoder: top level joining front end, group queue and serialiser.
// A group's first character passes the queue slot, the group register and the output word.
// Throughput: one byte per cycle in unless full, one character per cycle out while the output
// word is free; a group of three bytes occupies the serialiser for four characters.
// The serialiser's one-character-per-cycle output register sets the sustained rate.
// Reset (arst_n low, asynchronous) clears pending bytes, the queue and the output word.
`timescale 1ns / 1ps

module base64_stream_encoder
	import b64e_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = GROUP_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  item,
	output logic      empty,
	input  logic      pop,
	output out_word_t result
);

	logic   grp_push;
	group_t grp_wdata;
	logic   grp_full;
	logic   grp_valid;
	group_t grp_rdata;
	logic   grp_take;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.grp_push (grp_push),
		.grp_data (grp_wdata),
		.grp_full (grp_full)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (grp_push),
		.wr_data  (grp_wdata),
		.full     (grp_full),
		.rd_valid (grp_valid),
		.rd_data  (grp_rdata),
		.rd_en    (grp_take)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_data  (grp_rdata),
		.grp_take  (grp_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
